// ===== hdl/bmkd_pkg.sv =====
package bmkd_pkg;

	localparam int KEY_BYTES_DEF = 32;
	localparam int INIT_LEN      = 32;
	localparam int MIX_STEPS     = 256;
	localparam logic [7:0] ROUND_COUNT_RST = 8'd10;

	// power-on contents of the mixing table
	localparam logic [7:0] INIT_TABLE [INIT_LEN] = '{
		8'd83,  8'd41,  8'd201, 8'd107, 8'd175, 8'd150, 8'd205, 8'd119,
		8'd188, 8'd140, 8'd154, 8'd210, 8'd72,  8'd30,  8'd194, 8'd189,
		8'd130, 8'd9,   8'd134, 8'd201, 8'd11,  8'd145, 8'd29,  8'd179,
		8'd192, 8'd0,   8'd125, 8'd209, 8'd184, 8'd132, 8'd207, 8'd219
	};

	// entries beyond the fixed table start at zero
	function automatic logic [7:0] init_byte(input logic [7:0] idx);
		logic [7:0] val;
		val = 8'd0;
		if (idx < 8'(INIT_LEN)) begin
			val = INIT_TABLE[idx[4:0]];
		end
		return val;
	endfunction

	typedef enum logic [3:0] {
		S_LOAD,
		S_P1_RD,
		S_P1_UPD,
		S_P2_RD,
		S_P2_UPD,
		S_P3_RD,
		S_P3_NXT,
		S_P3_UPD,
		S_OUT_RD,
		S_OUT_VALID
	} state_t;

	typedef struct packed {
		logic idx_clr;
		logic idx_inc;
		logic step_clr;
		logic step_inc;
		logic rnd_clr;
		logic rnd_inc;
		logic key_rd;
		logic mix_rd;
		logic mix_rd_next;
		logic hold_x;
		logic key_load;
		logic p1_upd;
		logic p2_upd;
		logic p3_upd;
		logic last_load;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic step_last;
		logic round_last;
		logic round_zero;
	} status_t;

endpackage

// ===== hdl/bmkd_ctrl.sv =====
module bmkd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bmkd_pkg::status_t status,
	output bmkd_pkg::cmd_t    cmd
);

	bmkd_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmkd_pkg::S_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			bmkd_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.key_load = 1'b1;
					if (status.idx_last) begin
						cmd.idx_clr = 1'b1;
						cmd.rnd_clr = 1'b1;
						state_nxt   = status.round_zero ? bmkd_pkg::S_OUT_RD
						                                : bmkd_pkg::S_P1_RD;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			bmkd_pkg::S_P1_RD: begin
				cmd.key_rd = 1'b1;
				cmd.mix_rd = 1'b1;
				state_nxt  = bmkd_pkg::S_P1_UPD;
			end
			bmkd_pkg::S_P1_UPD: begin
				cmd.p1_upd = 1'b1;
				if (status.idx_last) begin
					cmd.idx_clr  = 1'b1;
					cmd.step_clr = 1'b1;
					state_nxt    = bmkd_pkg::S_P2_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = bmkd_pkg::S_P1_RD;
				end
			end
			bmkd_pkg::S_P2_RD: begin
				cmd.mix_rd = 1'b1;
				state_nxt  = bmkd_pkg::S_P2_UPD;
			end
			bmkd_pkg::S_P2_UPD: begin
				cmd.p2_upd   = 1'b1;
				cmd.step_inc = 1'b1;
				if (status.step_last) begin
					cmd.idx_clr = 1'b1;
					state_nxt   = bmkd_pkg::S_P3_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = bmkd_pkg::S_P2_RD;
				end
			end
			bmkd_pkg::S_P3_RD: begin
				cmd.key_rd = 1'b1;
				cmd.mix_rd = 1'b1;
				state_nxt  = bmkd_pkg::S_P3_NXT;
			end
			bmkd_pkg::S_P3_NXT: begin
				cmd.hold_x      = 1'b1;
				cmd.mix_rd      = 1'b1;
				cmd.mix_rd_next = 1'b1;
				state_nxt       = bmkd_pkg::S_P3_UPD;
			end
			bmkd_pkg::S_P3_UPD: begin
				cmd.p3_upd = 1'b1;
				if (status.idx_last) begin
					cmd.idx_clr = 1'b1;
					if (status.round_last) begin
						state_nxt = bmkd_pkg::S_OUT_RD;
					end else begin
						cmd.rnd_inc = 1'b1;
						state_nxt   = bmkd_pkg::S_P1_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = bmkd_pkg::S_P3_RD;
				end
			end
			bmkd_pkg::S_OUT_RD: begin
				cmd.key_rd    = 1'b1;
				cmd.last_load = 1'b1;
				state_nxt     = bmkd_pkg::S_OUT_VALID;
			end
			bmkd_pkg::S_OUT_VALID: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.idx_last) begin
						cmd.idx_clr = 1'b1;
						state_nxt   = bmkd_pkg::S_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt   = bmkd_pkg::S_OUT_RD;
					end
				end
			end
			default: begin
				state_nxt = bmkd_pkg::S_LOAD;
			end
		endcase
	end

endmodule

// ===== hdl/bmkd_datapath.sv =====
module bmkd_datapath #(
	parameter int KEY_BYTES = bmkd_pkg::KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	input  logic [7:0]        key_byte,
	output logic [7:0]        derived_byte,
	output logic              last,
	input  bmkd_pkg::cmd_t    cmd,
	output bmkd_pkg::status_t status
);

	localparam int IW = $clog2(KEY_BYTES);

	logic [7:0]    round_count_q;
	logic [7:0]    rnd_q;
	logic [7:0]    step_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_nxt;
	logic          idx_last;

	logic [7:0]    sum_q;
	logic [7:0]    mix_x_q;
	logic [7:0]    mix_rd_q;
	logic [7:0]    key_rd_q;
	logic          last_q;

	logic [7:0]          key_mem [KEY_BYTES];
	logic [7:0]          mix_mem [KEY_BYTES];
	logic [KEY_BYTES-1:0] mix_vld_q;

	logic [IW-1:0] mix_ra;
	logic [7:0]    m_p1, m_p2, m_p3;
	logic          mix_we;
	logic [7:0]    mix_wd;
	logic          key_we;
	logic [7:0]    key_wd;

	assign idx_last = (idx_q == IW'(KEY_BYTES - 1));
	assign idx_nxt  = idx_last ? '0 : idx_q + 1'b1;
	assign mix_ra   = cmd.mix_rd_next ? idx_nxt : idx_q;

	assign status.idx_last   = idx_last;
	assign status.step_last  = (step_q == 8'(bmkd_pkg::MIX_STEPS - 1));
	assign status.round_last = ({1'b0, rnd_q} + 9'd1) == {1'b0, round_count_q};
	assign status.round_zero = (round_count_q == 8'd0);

	// per-pass arithmetic, all modulo 256
	assign m_p1 = mix_rd_q + key_rd_q;
	assign m_p2 = mix_rd_q + sum_q;
	assign m_p3 = mix_x_q + mix_rd_q + sum_q;

	always_comb begin
		mix_we = cmd.p1_upd | cmd.p2_upd | cmd.p3_upd;
		mix_wd = m_p3;
		if (cmd.p1_upd) begin
			mix_wd = m_p1;
		end else if (cmd.p2_upd) begin
			mix_wd = m_p2;
		end
		key_we = cmd.key_load | cmd.p3_upd;
		key_wd = cmd.key_load ? key_byte : (key_rd_q ^ m_p3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= bmkd_pkg::ROUND_COUNT_RST;
			rnd_q         <= '0;
			step_q        <= '0;
			idx_q         <= '0;
			sum_q         <= '0;
			mix_vld_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				round_count_q <= cfg_wr_data;
			end
			if (cmd.rnd_clr) begin
				rnd_q <= '0;
			end else if (cmd.rnd_inc) begin
				rnd_q <= rnd_q + 8'd1;
			end
			if (cmd.step_clr) begin
				step_q <= '0;
			end else if (cmd.step_inc) begin
				step_q <= step_q + 8'd1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nxt;
			end
			if (cmd.p1_upd) begin
				sum_q <= sum_q + m_p1;
			end else if (cmd.p2_upd) begin
				sum_q <= sum_q + m_p2;
			end else if (cmd.p3_upd) begin
				sum_q <= sum_q + m_p3 + 8'(idx_q);
			end
			if (mix_we) begin
				mix_vld_q[idx_q] <= 1'b1;
			end
		end
	end

	// table entries not yet written read back as their power-on value
	always_ff @(posedge clk) begin
		if (mix_we) begin
			mix_mem[idx_q] <= mix_wd;
		end
		if (cmd.mix_rd) begin
			mix_rd_q <= mix_vld_q[mix_ra] ? mix_mem[mix_ra] : bmkd_pkg::init_byte(8'(mix_ra));
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[idx_q] <= key_wd;
		end
		if (cmd.key_rd) begin
			key_rd_q <= key_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_x) begin
			mix_x_q <= mix_rd_q;
		end
		if (cmd.last_load) begin
			last_q <= idx_last;
		end
	end

	assign derived_byte = key_rd_q;
	assign last         = last_q;

endmodule

// ===== hdl/byte_mixing_key_derivation_unit.sv =====
// Byte-mixing key derivation. Key bytes arrive one per transfer on the slave
// stream, byte zero first; one transfer per cycle while loading. After the
// last of KEY_BYTES bytes the unit runs round_count rounds (reset 10) and then
// sends the KEY_BYTES derived bytes on the master stream, tlast on the final
// one. tready stays low from the last key byte until the final derived byte
// is taken. The mixing table has a single read port with registered data, so
// each table update is split into a read state and an update state. A round
// is a table accumulate pass over the key bytes, 256 mixing steps and a
// keystream pass that reads two table entries per key byte. Zero rounds
// passes the key straight through. Mixing table and running sum carry over
// from one key to the next; the table starts from its fixed power-on
// contents through per-entry valid flags, so no clearing pass is needed
// after reset. round_count is written through cfg_wr_en/cfg_wr_data and is
// to be changed only while the unit is idle.
module byte_mixing_key_derivation_unit #(
	parameter int KEY_BYTES = bmkd_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: round_count
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	// key byte stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] key_byte
	// derived byte stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] derived_byte
	output logic       m_axis_tlast    // last
);

	bmkd_pkg::cmd_t    cmd;
	bmkd_pkg::status_t status;

	// sequencer: load, three passes per round, output
	bmkd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// key store, mixing table, running sum and counters
	bmkd_datapath #(
		.KEY_BYTES (KEY_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.key_byte     (s_axis_tdata),
		.derived_byte (m_axis_tdata),
		.last         (m_axis_tlast),
		.cmd          (cmd),
		.status       (status)
	);

endmodule
